// ===== hdl/tca_pkg.sv =====
// ----------------------------------------------------------------------------
// tca_pkg
// Shared widths, codes and control types of the touch coordinate averager.
// ----------------------------------------------------------------------------
package tca_pkg;

   localparam int RAW_W      = 16;   // raw converter word
   localparam int OFS_W      = 12;   // calibration offset
   localparam int GAIN_W     = 16;   // Q0.16 gain
   localparam int POS_W      = 14;   // calibrated position, two's complement
   localparam int MAG0_W     = 13;   // magnitude of one calibrated sample
   localparam int FRAC_W     = 16;   // fraction bits of the gain
   localparam int RAW_SHIFT  = 3;    // converter words carry three padding bits
   localparam int FULL_SCALE = 4096; // axis inversion point
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;

   typedef logic [1:0]              status_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [RAW_W-1:0]        raw_type;
   typedef logic [OFS_W-1:0]        offset_type;
   typedef logic [GAIN_W-1:0]       gain_type;
   typedef logic [CSR_IDX_W-1:0]    csr_index_type;
   typedef logic [CSR_W-1:0]        csr_data_type;

   localparam status_type STATUS_NONE    = 2'd0;
   localparam status_type STATUS_FILLING = 2'd1;
   localparam status_type STATUS_VALID   = 2'd2;

   localparam csr_index_type CSR_Y_OFFSET = 2'd0;
   localparam csr_index_type CSR_Y_GAIN   = 2'd1;
   localparam csr_index_type CSR_X_OFFSET = 2'd2;
   localparam csr_index_type CSR_X_GAIN   = 2'd3;

   localparam offset_type Y_OFFSET_RESET = 12'd280;
   localparam gain_type   Y_GAIN_RESET   = 16'd6139;
   localparam offset_type X_OFFSET_RESET = 12'd330;
   localparam gain_type   X_GAIN_RESET   = 16'd4546;

   // Operation that one microcode step asks of both axis lanes.
   typedef enum logic [2:0] {
      LOP_NONE,
      LOP_LOAD,   // invert and offset the raw word
      LOP_STORE,  // scale by the gain, write the ring, clear the accumulator
      LOP_SCAN,   // add one ring entry, watch for a zero entry
      LOP_MUL,    // multiply the sum magnitude by the reciprocal of the depth
      LOP_REM,    // quotient estimate and remainder check
      LOP_FIN,    // corrected, signed quotient into the held position
      LOP_CLEAR   // pen up: clear ring and held position
   } lane_op_type;

   // Sequencer steps, in program order.
   typedef enum logic [3:0] {
      ST_WAIT,
      ST_STORE,
      ST_SCAN,
      ST_TEST,
      ST_REM,
      ST_FIN,
      ST_CLEAR,
      ST_HOLD,
      ST_OUT
   } step_type;

   typedef enum logic [2:0] {
      COND_NEXT,  // fall through
      COND_GOTO,  // jump always
      COND_REQ,   // wait for an item, jump on pen up
      COND_LOOP,  // jump back until the last ring entry is read
      COND_ZERO,  // jump when a zero Y entry was seen
      COND_OUT    // wait for the result register, then jump
   } cond_type;

   typedef struct packed {
      lane_op_type op;
      cond_type    cond;
      step_type    target;
      logic        req_ready;
      logic        emit;
      logic        status_we;
      status_type  status;
   } ucode_type;

   // Control that the sequencer hands to the datapath and the top level.
   typedef struct packed {
      lane_op_type op;
      logic        req_ready;
      logic        emit;
      logic        status_we;
      status_type  status;
   } seq_ctl_type;

endpackage

// ===== hdl/tca_lane.sv =====
// ----------------------------------------------------------------------------
// tca_lane
// One axis: calibration, sample ring, ring sum and division by the depth.
// ----------------------------------------------------------------------------
module tca_lane #(
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tca_pkg::lane_op_type     op,
   input  tca_pkg::raw_type         raw,
   input  tca_pkg::offset_type      offset,
   input  tca_pkg::gain_type        gain,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic                     zero_seen,
   output tca_pkg::pos_type         held
);
   import tca_pkg::*;

   localparam int SUM_W = POS_W + $clog2(DEPTH);
   localparam int MAG_W = SUM_W - 1;
   localparam int MB_W  = (MAG_W > GAIN_W) ? MAG_W : GAIN_W;
   localparam int P_W   = MAG_W + MB_W;
   // Reciprocal of the depth; the quotient estimate is at most one too small.
   localparam int unsigned RECIP = (2 ** MAG_W) / DEPTH;

   pos_type                  ring_ff [DEPTH];
   pos_type                  held_ff, held_in;
   pos_type                  v_ff, v_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in, acc_abs;
   logic                     zero_ff;
   logic [P_W-1:0]           prod_ff;
   logic [MAG_W-1:0]         mag_ff, acc_mag, q0, qd, rem, q0_ff, q_sum;
   logic                     sign_ff, bump_ff, bump_in;
   logic                     cal_neg;
   pos_type                  cal_abs, entry_in, ring_rd;
   logic [MAG0_W-1:0]        cal_mag, scaled;
   logic [POS_W-1:0]         scaled_ext, q_pos;
   logic [MAG_W-1:0]         mul_a;
   logic [MB_W-1:0]          mul_b;
   logic [P_W-1:0]           mul_p;

   assign v_in = $signed(POS_W'(FULL_SCALE) - POS_W'(raw[RAW_W-1:RAW_SHIFT])
                         - POS_W'(offset));

   assign cal_neg = v_ff[POS_W-1];
   assign cal_abs = cal_neg ? -v_ff : v_ff;
   assign cal_mag = cal_abs[MAG0_W-1:0];

   assign acc_abs = acc_ff[SUM_W-1] ? -acc_ff : acc_ff;
   assign acc_mag = acc_abs[MAG_W-1:0];

   // One multiplier serves both the gain and the reciprocal.
   always_comb begin
      if (op == LOP_MUL) begin
         mul_a = acc_mag;
         mul_b = MB_W'(RECIP);
      end else begin
         mul_a = MAG_W'(cal_mag);
         mul_b = MB_W'(gain);
      end
   end

   assign mul_p = P_W'(mul_a) * P_W'(mul_b);

   assign scaled     = mul_p[FRAC_W +: MAG0_W];
   assign scaled_ext = POS_W'(scaled);
   assign entry_in   = cal_neg ? -$signed(scaled_ext) : $signed(scaled_ext);

   assign ring_rd = ring_ff[rd_idx];
   assign acc_in  = acc_ff + SUM_W'(ring_rd);

   assign q0      = prod_ff[MAG_W +: MAG_W];
   assign qd      = q0 * MAG_W'(DEPTH);
   assign rem     = mag_ff - qd;
   assign bump_in = (rem >= MAG_W'(DEPTH));

   assign q_sum   = q0_ff + MAG_W'(bump_ff);
   assign q_pos   = q_sum[POS_W-1:0];
   assign held_in = sign_ff ? -$signed(q_pos) : $signed(q_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         held_ff <= '0;
      end else begin
         unique case (op)
            LOP_STORE: ring_ff[wr_idx] <= entry_in;
            LOP_CLEAR: begin
               for (int i = 0; i < DEPTH; i++) begin
                  ring_ff[i] <= '0;
               end
               held_ff <= '0;
            end
            LOP_FIN: held_ff <= held_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (op)
         LOP_LOAD: v_ff <= v_in;
         LOP_STORE: begin
            acc_ff  <= '0;
            zero_ff <= 1'b0;
         end
         LOP_SCAN: begin
            acc_ff  <= acc_in;
            zero_ff <= zero_ff | (ring_rd == '0);
         end
         LOP_MUL: begin
            prod_ff <= mul_p;
            mag_ff  <= acc_mag;
            sign_ff <= acc_ff[SUM_W-1];
         end
         LOP_REM: begin
            q0_ff   <= q0;
            bump_ff <= bump_in;
         end
         default: ;
      endcase
   end

   assign zero_seen = zero_ff;
   assign held      = held_ff;

endmodule

// ===== hdl/tca_seq.sv =====
// ----------------------------------------------------------------------------
// tca_seq
// Microcode sequencer: step counter, program table and loop counter.
// ----------------------------------------------------------------------------
module tca_seq #(
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_pen_up,
   input  logic                     zero_seen,
   input  logic                     out_free,
   output tca_pkg::seq_ctl_type     ctl,
   output logic [$clog2(DEPTH)-1:0] rd_idx
);
   import tca_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   step_type         step_ff, step_in, step_nxt;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             last;
   ucode_type        word;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = '{op: LOP_NONE, cond: COND_NEXT, target: ST_WAIT, req_ready: 1'b0,
            emit: 1'b0, status_we: 1'b0, status: STATUS_NONE};
      unique case (s)
         ST_WAIT: begin
            w.op = LOP_LOAD;  w.cond = COND_REQ;  w.target = ST_CLEAR;
            w.req_ready = 1'b1;
         end
         ST_STORE: w.op = LOP_STORE;
         ST_SCAN: begin
            w.op = LOP_SCAN;  w.cond = COND_LOOP; w.target = ST_SCAN;
         end
         ST_TEST: begin
            w.op = LOP_MUL;   w.cond = COND_ZERO; w.target = ST_HOLD;
         end
         ST_REM:  w.op = LOP_REM;
         ST_FIN: begin
            w.op = LOP_FIN;   w.cond = COND_GOTO; w.target = ST_OUT;
            w.status_we = 1'b1; w.status = STATUS_VALID;
         end
         ST_CLEAR: begin
            w.op = LOP_CLEAR; w.cond = COND_GOTO; w.target = ST_OUT;
            w.status_we = 1'b1; w.status = STATUS_NONE;
         end
         ST_HOLD: begin
            w.status_we = 1'b1; w.status = STATUS_FILLING;
         end
         ST_OUT: begin
            w.cond = COND_OUT; w.target = ST_WAIT; w.emit = 1'b1;
         end
         default: begin
            w.cond = COND_GOTO; w.target = ST_WAIT;
         end
      endcase
      return w;
   endfunction

   assign word     = ucode_rom(step_ff);
   assign step_nxt = step_type'(4'(step_ff + 4'd1));
   assign last     = (cnt_ff == IDX_W'(DEPTH - 1));

   always_comb begin
      unique case (word.cond)
         COND_NEXT: step_in = step_nxt;
         COND_GOTO: step_in = word.target;
         COND_REQ:  step_in = !req_valid ? step_ff : (req_pen_up ? word.target : step_nxt);
         COND_LOOP: step_in = last ? step_nxt : word.target;
         COND_ZERO: step_in = zero_seen ? word.target : step_nxt;
         COND_OUT:  step_in = out_free ? word.target : step_ff;
         default:   step_in = ST_WAIT;
      endcase
   end

   always_comb begin
      unique case (word.op)
         LOP_STORE: cnt_in = '0;
         LOP_SCAN:  cnt_in = cnt_ff + IDX_W'(1);
         default:   cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   always_comb begin
      ctl.op        = (word.op == LOP_LOAD && !req_valid) ? LOP_NONE : word.op;
      ctl.req_ready = word.req_ready;
      ctl.emit      = word.emit && out_free;
      ctl.status_we = word.status_we;
      ctl.status    = word.status;
   end

   assign rd_idx = cnt_ff;

endmodule

// ===== hdl/touch_coordinate_average.sv =====
// ----------------------------------------------------------------------------
// touch_coordinate_average
// Moving average over the last DEPTH calibrated touch samples, per axis.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            fields
//   req      in         req_valid/req_ready  req_pen_up, req_raw_y, req_raw_x
//   rsp      out        rsp_valid/rsp_ready  rsp_touch_status, rsp_y_pos, rsp_x_pos
//   csr      in         csr_we               csr_index, csr_wdata
//
// A pen-down item goes through the store step, ring scan and test, then the
// remainder and final steps for a new average, or the hold step when the
// ring is not yet full; a pen-up item goes through the clear step. Each ends
// in the output step. The loop step reads one entry of each ring per cycle.
// One item is worked on at a time; the result register lets the next item
// in while the previous result still waits for rsp_ready. The last step of
// an item stalls only while that register still holds an unaccepted result.
// Reset is synchronous and leaves the rings and held positions at zero,
// the write index at zero and the calibration registers at their defaults.
//
// Each axis goes through one lane: invert and offset the raw word, scale it
// by the Q0.16 gain truncating toward zero, and store it at the write index.
// The sequencer then walks the ring, summing entries and looking for a zero
// Y entry. A zero entry means the ring is not yet full and the held
// positions stay. Otherwise the sum is divided by DEPTH with a reciprocal
// multiply and a one-step correction, and becomes the new held position.
// The write index moves on every item, pen-up items included.
module touch_coordinate_average #(
   parameter int DEPTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_pen_up,
   input  tca_pkg::raw_type       req_raw_y,
   input  tca_pkg::raw_type       req_raw_x,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tca_pkg::status_type    rsp_touch_status,
   output tca_pkg::pos_type       rsp_y_pos,
   output tca_pkg::pos_type       rsp_x_pos,
   input  logic                   csr_we,
   input  tca_pkg::csr_index_type csr_index,
   input  tca_pkg::csr_data_type  csr_wdata
);
   import tca_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   // Calibration registers.
   offset_type y_offset_ff, x_offset_ff;
   gain_type   y_gain_ff, x_gain_ff;

   // Write index into both rings.
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;

   seq_ctl_type      ctl;
   logic [IDX_W-1:0] rd_idx;
   logic             y_zero;
   pos_type          y_held, x_held;
   status_type       status_ff;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   pos_type          rsp_y_ff, rsp_x_ff;
   logic             out_free;

   assign req_ready = ctl.req_ready;
   assign accept    = req_valid && ctl.req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_offset_ff <= Y_OFFSET_RESET;
         y_gain_ff   <= Y_GAIN_RESET;
         x_offset_ff <= X_OFFSET_RESET;
         x_gain_ff   <= X_GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_Y_OFFSET: y_offset_ff <= csr_wdata[OFS_W-1:0];
            CSR_Y_GAIN:   y_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_X_OFFSET: x_offset_ff <= csr_wdata[OFS_W-1:0];
            CSR_X_GAIN:   x_gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // The index advances at acceptance, so the store step already sees the
   // slot that this item writes.
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = (idx_ff == IDX_W'(DEPTH - 1)) ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   tca_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_pen_up (req_pen_up),
      .zero_seen  (y_zero),
      .out_free   (out_free),
      .ctl        (ctl),
      .rd_idx     (rd_idx)
   );

   tca_lane #(
      .DEPTH (DEPTH)
   ) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .op        (ctl.op),
      .raw       (req_raw_y),
      .offset    (y_offset_ff),
      .gain      (y_gain_ff),
      .wr_idx    (idx_ff),
      .rd_idx    (rd_idx),
      .zero_seen (y_zero),
      .held      (y_held)
   );

   // Only the Y ring decides whether the rings count as full.
   tca_lane #(
      .DEPTH (DEPTH)
   ) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .op        (ctl.op),
      .raw       (req_raw_x),
      .offset    (x_offset_ff),
      .gain      (x_gain_ff),
      .wr_idx    (idx_ff),
      .rd_idx    (rd_idx),
      .zero_seen (),
      .held      (x_held)
   );

   always_ff @(posedge clock) begin
      if (ctl.status_we) begin
         status_ff <= ctl.status;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_status_ff <= status_ff;
         rsp_y_ff      <= y_held;
         rsp_x_ff      <= x_held;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touch_status = rsp_status_ff;
   assign rsp_y_pos        = rsp_y_ff;
   assign rsp_x_pos        = rsp_x_ff;

endmodule

// ===== hdl/tca_checker.sv =====
// ----------------------------------------------------------------------------
// tca_checker
// Port-level checks of the touch coordinate averager, bound to the top level.
// ----------------------------------------------------------------------------
module tca_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tca_pkg::status_type    rsp_touch_status,
   input tca_pkg::pos_type       rsp_y_pos,
   input tca_pkg::pos_type       rsp_x_pos
);
   import tca_pkg::*;

   // A result that waits keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_touch_status)
         && $stable(rsp_y_pos) && $stable(rsp_x_pos))
      else $error("result changed while stalled");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_touch_status == STATUS_NONE
         || rsp_touch_status == STATUS_FILLING || rsp_touch_status == STATUS_VALID)
      else $error("unknown touch status");

   // A pen-up result reports cleared positions.
   a_pen_up_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_touch_status == STATUS_NONE |-> rsp_y_pos == '0 && rsp_x_pos == '0)
      else $error("no-touch result with nonzero position");

endmodule

bind touch_coordinate_average tca_checker u_tca_checker (.*);
